// File: rtl/f16fr_pkg.sv
// ----------------------------------------------------------------------------
// f16fr_pkg
// Shared types and constants for the Fletcher-16 frame receiver.
// ----------------------------------------------------------------------------
package f16fr_pkg;

  // receive buffer limit: the byte at this index is dropped
  localparam int BufferBytes = 32;
  // index counter holds 0 .. BufferBytes
  localparam int IdxW        = $clog2(BufferBytes + 1);

  localparam logic [7:0] FletcherMod = 8'd255;
  localparam logic [7:0] ServoCmd    = 8'h53;   // 'S'

  // request type codes
  localparam logic ReqByte = 1'b0;
  localparam logic ReqTick = 1'b1;

  typedef struct packed {
    logic       req_type;
    logic [7:0] rx_byte;
  } rx_item_t;

  typedef struct packed {
    logic               frame_done;
    logic               check_ok;
    logic               servo_command;
    logic [7:0]         servo_id;
    logic signed [15:0] servo_position;
    logic               timeout_level;
    logic               timeout_flush;
    logic               overflow_drop;
  } rx_result_t;

endpackage

// File: rtl/f16fr_parser.sv
// ----------------------------------------------------------------------------
// f16fr_parser
// Frame state, running Fletcher-16 sums and timeout logic; computes the
// result of one transaction and updates the state when it is accepted.
// ----------------------------------------------------------------------------
module f16fr_parser (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  accept_i,
  input  f16fr_pkg::rx_item_t   item_i,
  output f16fr_pkg::rx_result_t result_o
);

  logic [f16fr_pkg::IdxW-1:0] idx_q, idx_d;
  logic [f16fr_pkg::IdxW-1:0] head_idx;
  logic [7:0] size_q, size_d;
  logic [7:0] sum_lo_q, sum_lo_d;
  logic [7:0] sum_hi_q, sum_hi_d;
  logic [7:0] prev_q, prev_d;
  logic [7:0] head_q [4];
  logic [7:0] head_d [4];
  logic       late_q, late_d;
  logic       pin_q, pin_d;
  logic [7:0] fold_lo, fold_hi, first_lo;
  logic [8:0] idx_ext, size_p1;
  f16fr_pkg::rx_result_t res;

  // (a + b) mod 255 for a < 255, b <= 255: the sum stays below 510
  function automatic logic [7:0] add_mod(input logic [7:0] a, input logic [7:0] b);
    logic [8:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, f16fr_pkg::FletcherMod}) begin
      s = s - {1'b0, f16fr_pkg::FletcherMod};
    end
    return s[7:0];
  endfunction

  assign fold_lo  = add_mod(sum_lo_q, item_i.rx_byte);
  assign fold_hi  = add_mod(sum_hi_q, fold_lo);
  assign first_lo = add_mod(8'd0, item_i.rx_byte);
  assign idx_ext  = 9'(idx_q);
  assign size_p1  = {1'b0, size_q} + 9'd1;
  assign head_idx = idx_q - f16fr_pkg::IdxW'(1);

  always_comb begin
    idx_d    = idx_q;
    size_d   = size_q;
    sum_lo_d = sum_lo_q;
    sum_hi_d = sum_hi_q;
    prev_d   = prev_q;
    head_d   = head_q;
    late_d   = late_q;
    pin_d    = pin_q;
    res      = '0;

    if (item_i.req_type == f16fr_pkg::ReqTick) begin
      if (late_q) begin
        // second tick with no byte: discard a partial frame
        if (idx_q != '0) begin
          idx_d               = '0;
          pin_d               = 1'b0;
          res.timeout_flush   = 1'b1;
        end
      end else begin
        late_d = 1'b1;
        pin_d  = 1'b1;
      end
    end else begin
      if (idx_q < f16fr_pkg::IdxW'(f16fr_pkg::BufferBytes)) begin
        if (idx_q >= f16fr_pkg::IdxW'(1) && idx_q <= f16fr_pkg::IdxW'(4)) begin
          head_d[head_idx[1:0]] = item_i.rx_byte;
        end
        if (idx_q == '0) begin
          size_d = item_i.rx_byte;
          if (item_i.rx_byte != 8'd0) begin
            sum_lo_d = first_lo;
            sum_hi_d = first_lo;
          end else begin
            sum_lo_d = 8'd0;
            sum_hi_d = 8'd0;
          end
          idx_d = f16fr_pkg::IdxW'(1);
        end else if (idx_ext == size_p1) begin
          // last check byte: sum2 came in the byte before
          res.frame_done = 1'b1;
          res.check_ok   = (prev_q == sum_hi_q) && (item_i.rx_byte == sum_lo_q);
          if (res.check_ok && head_d[0] == f16fr_pkg::ServoCmd) begin
            res.servo_command  = 1'b1;
            res.servo_id       = head_d[1];
            res.servo_position = signed'({head_d[2], head_d[3]});
          end
          idx_d = '0;
        end else begin
          if (idx_ext < {1'b0, size_q}) begin
            sum_lo_d = fold_lo;
            sum_hi_d = fold_hi;
          end
          idx_d = idx_q + f16fr_pkg::IdxW'(1);
        end
        prev_d = item_i.rx_byte;
      end else begin
        idx_d             = '0;
        res.overflow_drop = 1'b1;
      end
      late_d = 1'b0;
      pin_d  = 1'b0;
    end

    res.timeout_level = pin_d;
  end

  assign result_o = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q    <= '0;
      size_q   <= '0;
      sum_lo_q <= '0;
      sum_hi_q <= '0;
      prev_q   <= '0;
      head_q   <= '{default: '0};
      late_q   <= 1'b0;
      pin_q    <= 1'b0;
    end else if (accept_i) begin
      idx_q    <= idx_d;
      size_q   <= size_d;
      sum_lo_q <= sum_lo_d;
      sum_hi_q <= sum_hi_d;
      prev_q   <= prev_d;
      head_q   <= head_d;
      late_q   <= late_d;
      pin_q    <= pin_d;
    end
  end

endmodule

// File: rtl/f16fr_out_stage.sv
// ----------------------------------------------------------------------------
// f16fr_out_stage
// Result register with valid/ready; takes a new result in the cycle the
// held one is taken.
// ----------------------------------------------------------------------------
module f16fr_out_stage (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  f16fr_pkg::rx_result_t res_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output f16fr_pkg::rx_result_t out_o
);

  logic                  valid_q, valid_d;
  f16fr_pkg::rx_result_t data_q, data_d;

  assign in_ready_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    data_d  = data_q;
    if (in_ready_o) begin
      valid_d = in_valid_i;
      data_d  = res_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign out_valid_o = valid_q;
  assign out_o       = data_q;

endmodule

// File: rtl/fletcher16_frame_receiver.sv
// latency: a result is registered and appears in the cycle after its transaction is accepted
// throughput: 1 transaction per cycle; the frame state updates in the accept cycle
// and a held result lets the next transaction in only in the cycle it is taken
// reset: rst_ni (async, active low) clears frame state, sums, head bytes,
// timeout flags and the result valid
// ----------------------------------------------------------------------------
// fletcher16_frame_receiver
// Length-prefixed frame receiver with Fletcher-16 check and servo decode.
// ----------------------------------------------------------------------------
module fletcher16_frame_receiver (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  f16fr_pkg::rx_item_t   in_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output f16fr_pkg::rx_result_t out_o
);

  f16fr_pkg::rx_result_t step_res;
  logic                  accept;

  assign accept = in_valid_i && in_ready_o;

  f16fr_parser u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .item_i   (in_i),
    .result_o (step_res)
  );

  f16fr_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .res_i       (step_res),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_o)
  );

endmodule

// File: rtl/f16fr_checker.sv
// ----------------------------------------------------------------------------
// f16fr_checker
// Port-level assertions for the frame receiver, bound to the top level.
// ----------------------------------------------------------------------------
module f16fr_checker (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_ready_o,
  input logic                  out_valid_o,
  input logic                  out_ready_i,
  input f16fr_pkg::rx_result_t out_o
);

  // input stalls only behind a result that is not being taken
  a_ready_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !out_ready_i))
    else $error("input stalled with free result register");

  // every accepted transaction shows a result in the next cycle
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> out_valid_o)
    else $error("accepted transaction produced no result");

  a_servo_needs_check: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_o.servo_command) |-> (out_o.check_ok && out_o.frame_done))
    else $error("servo command without a good completed frame");

  // a flush or drop never completes a frame, a flush leaves the pin low
  a_event_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !((out_o.timeout_flush || out_o.overflow_drop) && out_o.frame_done)
                    && !(out_o.timeout_flush && out_o.timeout_level))
    else $error("inconsistent result flags");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(out_o)))
    else $error("stalled result changed");

endmodule

bind fletcher16_frame_receiver f16fr_checker u_checker (.*);

// File: verif/fletcher16_frame_receiver_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fletcher16_frame_receiver_test
// Self-checking bench for the Fletcher-16 frame receiver. A short table of
// bytes and ticks covers extreme positions, empty and short frames, a bad
// check and a timeout flush. Random frames follow: mostly well-formed, some
// corrupted, oversized or cut off by ticks. Each result is compared with a
// behavioral decoder or a table row's own result. Both sides idle in bursts.
// ----------------------------------------------------------------------------
module fletcher16_frame_receiver_test;

  localparam int StimItems   = 1000;
  localparam int TailItems   = 150;
  localparam int StallLimit  = 1000;
  localparam int DrainCycles = 4;
  localparam int TableRows   = 27;

  typedef struct {
    f16fr_pkg::rx_item_t   item;
    bit                    typed;
    f16fr_pkg::rx_result_t result;
  } stim_row_t;

  logic                  clk_i;
  logic                  rst_ni     = 1'b0;
  logic                  in_valid   = 1'b0;
  f16fr_pkg::rx_item_t   in_item    = '0;
  logic                  out_ready  = 1'b0;
  bit                    row_typed  = 1'b0;
  f16fr_pkg::rx_result_t row_result = '0;
  logic                  in_ready;
  logic                  out_valid;
  f16fr_pkg::rx_result_t out_result;

  // decoder state
  logic [f16fr_pkg::IdxW-1:0] rx_index;
  logic [7:0]      rx_size;
  logic [7:0]      sum_low;
  logic [7:0]      sum_high;
  logic [7:0]      last_byte;
  logic [7:0]      head_regs [4];
  logic            late_tick;
  logic            timeout_pin;

  f16fr_pkg::rx_result_t decoded_results [$];
  stim_row_t  directed_rows [TableRows];
  int         error_count = 0;
  int         items_sent  = 0;
  int         quiet_cycles = 0;
  int         gap_pct     = 0;
  int         stall_pct   = 0;
  int         stall_left  = 0;

  fletcher16_frame_receiver dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_i        (in_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_o       (out_result)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [7:0] mod255_add(logic [7:0] a, logic [7:0] b);
    return 8'((int'(a) + int'(b)) % int'(f16fr_pkg::FletcherMod));
  endfunction

  function automatic f16fr_pkg::rx_result_t outcome(bit done, bit ok, bit cmd,
                                                    logic [7:0] id, logic [15:0] pos,
                                                    bit level, bit flush);
    f16fr_pkg::rx_result_t r;
    r = '0;
    r.frame_done     = done;
    r.check_ok       = ok;
    r.servo_command  = cmd;
    r.servo_id       = id;
    r.servo_position = pos;
    r.timeout_level  = level;
    r.timeout_flush  = flush;
    return r;
  endfunction

  // advances the decoder by one transaction and returns its result
  function f16fr_pkg::rx_result_t frame_decode(f16fr_pkg::rx_item_t item);
    f16fr_pkg::rx_result_t r;
    logic [7:0] b;
    r = '0;
    b = item.rx_byte;
    if (item.req_type == f16fr_pkg::ReqTick) begin
      if (late_tick) begin
        if (rx_index != 0) begin
          rx_index    = '0;
          timeout_pin = 1'b0;
          r.timeout_flush = 1'b1;
        end
      end else begin
        late_tick   = 1'b1;
        timeout_pin = 1'b1;
      end
    end else begin
      if (rx_index < f16fr_pkg::BufferBytes) begin
        if (rx_index >= 1 && rx_index <= 4) head_regs[2'(rx_index - 1'b1)] = b;
        if (rx_index == 0) begin
          rx_size  = b;
          sum_low  = mod255_add(8'd0, b);
          sum_high = sum_low;
          rx_index = f16fr_pkg::IdxW'(1);
        end else if (int'(rx_index) == int'(rx_size) + 1) begin
          r.frame_done = 1'b1;
          r.check_ok   = (last_byte == sum_high) && (b == sum_low);
          if (r.check_ok && head_regs[0] == f16fr_pkg::ServoCmd) begin
            r.servo_command  = 1'b1;
            r.servo_id       = head_regs[1];
            r.servo_position = {head_regs[2], head_regs[3]};
          end
          rx_index = '0;
        end else begin
          if (int'(rx_index) < int'(rx_size)) begin
            sum_low  = mod255_add(sum_low, b);
            sum_high = mod255_add(sum_high, sum_low);
          end
          rx_index = rx_index + 1'b1;
        end
        last_byte = b;
      end else begin
        rx_index = '0;
        r.overflow_drop = 1'b1;
      end
      late_tick   = 1'b0;
      timeout_pin = 1'b0;
    end
    r.timeout_level = timeout_pin;
    return r;
  endfunction

  task automatic check_field(string name, int expected, int actual);
    if (expected != actual) begin
      error_count++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, expected, actual);
    end
  endtask

  // scoreboard and watchdog
  always @(posedge clk_i) begin : monitor
    f16fr_pkg::rx_result_t want;
    if (out_valid && out_ready) begin
      if (decoded_results.size() == 0) begin
        error_count++;
        $display("%0t: unexpected result, expected none, actual %p", $time, out_result);
      end else begin
        want = decoded_results.pop_front();
        check_field("frame_done", want.frame_done, out_result.frame_done);
        check_field("check_ok", want.check_ok, out_result.check_ok);
        check_field("servo_command", want.servo_command, out_result.servo_command);
        check_field("servo_id", want.servo_id, out_result.servo_id);
        check_field("servo_position", want.servo_position, out_result.servo_position);
        check_field("timeout_level", want.timeout_level, out_result.timeout_level);
        check_field("timeout_flush", want.timeout_flush, out_result.timeout_flush);
        check_field("overflow_drop", want.overflow_drop, out_result.overflow_drop);
      end
    end
    if (in_valid && in_ready) begin
      want = frame_decode(in_item);
      decoded_results.push_back(row_typed ? row_result : want);
    end
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles == StallLimit) begin
      $display("%0t: no transaction for %0d cycles", $time, StallLimit);
      $display("** fletcher16_frame_receiver: FAILED **");
      $finish;
    end
  end

  // result side back-pressure
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
      out_ready <= 1'b0;
      stall_left = $urandom_range(0, 15);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic drive_item(f16fr_pkg::rx_item_t item, bit typed,
                            f16fr_pkg::rx_result_t result);
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk_i);
    end
    in_valid   <= 1'b1;
    in_item    <= item;
    row_typed  <= typed;
    row_result <= result;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_byte(logic [7:0] b);
    f16fr_pkg::rx_item_t it;
    it.req_type = f16fr_pkg::ReqByte;
    it.rx_byte  = b;
    drive_item(it, 1'b0, '0);
  endtask

  task automatic send_tick();
    f16fr_pkg::rx_item_t it;
    it.req_type = f16fr_pkg::ReqTick;
    it.rx_byte  = 8'($urandom);
    drive_item(it, 1'b0, '0);
  endtask

  // two ticks bring a partial frame back to index zero
  task automatic resync();
    if (rx_index != 0) begin
      send_tick();
      send_tick();
    end
  endtask

  task automatic send_good_frame();
    int         size;
    int         pos;
    logic [7:0] frame_bytes [$];
    logic [7:0] s1;
    logic [7:0] s2;
    s1 = '0;
    s2 = '0;
    if ($urandom_range(0, 3) == 0) size = $urandom_range(7, f16fr_pkg::BufferBytes - 2);
    else size = $urandom_range(0, 6);
    frame_bytes.push_back(8'(size));
    for (int i = 1; i < size; i++) begin
      if (i == 1 && $urandom_range(0, 1) == 1) frame_bytes.push_back(f16fr_pkg::ServoCmd);
      else frame_bytes.push_back(8'($urandom));
    end
    foreach (frame_bytes[i]) begin
      s1 = mod255_add(s1, frame_bytes[i]);
      s2 = mod255_add(s2, s1);
    end
    // an empty frame reuses the size byte as the high check byte
    if (size != 0) frame_bytes.push_back(s2);
    frame_bytes.push_back(s1);
    if ($urandom_range(0, 9) == 0) begin
      pos = $urandom_range(1, frame_bytes.size() - 1);
      frame_bytes[pos] ^= 8'(1 << $urandom_range(0, 7));
    end
    resync();
    foreach (frame_bytes[i]) begin
      if ($urandom_range(0, 24) == 0) send_tick();
      send_byte(frame_bytes[i]);
    end
  endtask

  initial begin
    rx_index    = '0;
    rx_size     = '0;
    sum_low     = '0;
    sum_high    = '0;
    last_byte   = '0;
    head_regs   = '{default: '0};
    late_tick   = 1'b0;
    timeout_pin = 1'b0;

    directed_rows = '{
      '{'{f16fr_pkg::ReqTick, 8'h00}, 1'b1, outcome(0, 0, 0, 8'h00, 16'h0000, 1, 0)},
      // idle tick keeps the level
      '{'{f16fr_pkg::ReqTick, 8'hFF}, 1'b1, outcome(0, 0, 0, 8'h00, 16'h0000, 1, 0)},
      // empty frame
      '{'{f16fr_pkg::ReqByte, 8'h00}, 1'b1, outcome(0, 0, 0, 8'h00, 16'h0000, 0, 0)},
      '{'{f16fr_pkg::ReqByte, 8'h00}, 1'b1, outcome(1, 1, 0, 8'h00, 16'h0000, 0, 0)},
      // servo at the negative extreme
      '{'{f16fr_pkg::ReqByte, 8'h05}, 1'b0, '0},
      '{'{f16fr_pkg::ReqByte, 8'h53}, 1'b0, '0},
      '{'{f16fr_pkg::ReqByte, 8'h07}, 1'b0, '0},
      '{'{f16fr_pkg::ReqByte, 8'h80}, 1'b0, '0},
      '{'{f16fr_pkg::ReqByte, 8'h00}, 1'b0, '0},
      '{'{f16fr_pkg::ReqByte, 8'h7C}, 1'b0, '0},
      '{'{f16fr_pkg::ReqByte, 8'hDF}, 1'b1, outcome(1, 1, 1, 8'h07, 16'h8000, 0, 0)},
      // servo at the positive extreme
      '{'{f16fr_pkg::ReqByte, 8'h05}, 1'b0, '0},
      '{'{f16fr_pkg::ReqByte, 8'h53}, 1'b0, '0},
      '{'{f16fr_pkg::ReqByte, 8'hFF}, 1'b0, '0},
      '{'{f16fr_pkg::ReqByte, 8'h7F}, 1'b0, '0},
      '{'{f16fr_pkg::ReqByte, 8'hFF}, 1'b0, '0},
      '{'{f16fr_pkg::ReqByte, 8'h65}, 1'b0, '0},
      '{'{f16fr_pkg::ReqByte, 8'hD7}, 1'b1, outcome(1, 1, 1, 8'hFF, 16'h7FFF, 0, 0)},
      // empty frame with a bad low check byte
      '{'{f16fr_pkg::ReqByte, 8'h00}, 1'b0, '0},
      '{'{f16fr_pkg::ReqByte, 8'h01}, 1'b1, outcome(1, 0, 0, 8'h00, 16'h0000, 0, 0)},
      // short servo frame picks up a stale low position byte
      '{'{f16fr_pkg::ReqByte, 8'h02}, 1'b0, '0},
      '{'{f16fr_pkg::ReqByte, 8'h53}, 1'b0, '0},
      '{'{f16fr_pkg::ReqByte, 8'h57}, 1'b0, '0},
      '{'{f16fr_pkg::ReqByte, 8'h55}, 1'b0, '0},
      // partial frame discarded by two ticks
      '{'{f16fr_pkg::ReqByte, 8'h03}, 1'b0, '0},
      '{'{f16fr_pkg::ReqTick, 8'h5A}, 1'b0, '0},
      '{'{f16fr_pkg::ReqTick, 8'hA5}, 1'b1, outcome(0, 0, 0, 8'h00, 16'h0000, 0, 1)}
    };

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    gap_pct   = 20;
    stall_pct = 20;
    foreach (directed_rows[i])
      drive_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].result);

    while (items_sent < StimItems) begin
      if (items_sent >= StimItems - TailItems) begin
        gap_pct   = 0;
        stall_pct = 0;
      end else begin
        case ($urandom_range(0, 2))
          0: gap_pct = 0;
          1: gap_pct = 5;
          default: gap_pct = 30;
        endcase
        case ($urandom_range(0, 2))
          0: stall_pct = 0;
          1: stall_pct = 5;
          default: stall_pct = 30;
        endcase
      end
      case ($urandom_range(0, 99)) inside
        [0:59]: send_good_frame();
        [60:67]: begin
          // oversized frame runs into the buffer limit
          resync();
          send_byte(8'($urandom_range(f16fr_pkg::BufferBytes - 1, 255)));
          repeat (f16fr_pkg::BufferBytes) send_byte(8'($urandom));
        end
        [68:77]: begin
          int size;
          resync();
          size = $urandom_range(5, f16fr_pkg::BufferBytes - 2);
          send_byte(8'(size));
          repeat ($urandom_range(1, size)) send_byte(8'($urandom));
          send_tick();
          send_tick();
        end
        [78:87]: repeat ($urandom_range(1, 3)) send_tick();
        default: begin
          repeat ($urandom_range(1, 4)) begin
            if ($urandom_range(0, 1) == 1) send_tick();
            else send_byte(8'($urandom));
          end
        end
      endcase
    end

    in_valid <= 1'b0;
    while (decoded_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (error_count == 0 && decoded_results.size() == 0) begin
      $display("** fletcher16_frame_receiver: PASSED **");
    end else begin
      $display("** fletcher16_frame_receiver: FAILED **");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/f16fr_pkg.sv
rtl/f16fr_parser.sv
rtl/f16fr_out_stage.sv
rtl/fletcher16_frame_receiver.sv
rtl/f16fr_checker.sv
verif/fletcher16_frame_receiver_test.sv
